// File: rtl/tcw_pkg.sv
// Package for the text console writer: transfer structs, job codes and
// fixed field widths. No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  // Fixed field widths of the ports
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int WORD_W = 16;

  // Action codes on the command port
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Character codes and register reset
  localparam logic [7:0] NL_CODE    = 8'h0A;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h03;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]        action;
    logic [WORD_W-1:0] char_word;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [WORD_W-1:0] read_data;
    logic              scrolled;
  } res_t;

  // Classified job as the back end sees it
  typedef enum logic [2:0] {
    JOB_PUT,
    JOB_NEWLINE,
    JOB_CLEAR,
    JOB_READ,
    JOB_NOP
  } job_e;

  typedef struct packed {
    job_e              op;
    logic [WORD_W-1:0] word;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } job_t;

endpackage

// File: rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/tcw_queue.sv
// Short job queue between the front and back ends of the console writer.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_queue
  import tcw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t entry_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  job_t            store_q [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [CNTW-1:0] count_q, count_d;

  assign full_o  = (count_q == CNTW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = store_q[rptr_q];

  // Pointer and fill count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wptr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/tcw_front.sv
// Front end of the console writer: command transfer, attribute register
// and classification of each command into a job. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_front
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  cmd_t       cmd_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       q_full_i,
  input  logic       wipe_busy_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [7:0] attr_q;
  logic       read_ok;

  // Attribute register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      attr_q <= cfg_data_i;
    end
  end

  // Hold commands off while the queue is full or the store is being wiped
  assign busy_o = q_full_i || wipe_busy_i;
  assign push_o = start_i && !busy_o;

  assign read_ok = (int'(cmd_i.read_row) < ROWS) && (int'(cmd_i.read_col) < COLUMNS);

  // Classify: fill in attributes, spot newlines, drop reads off the screen
  always_comb begin
    job_o.op   = JOB_NOP;
    job_o.word = cmd_i.char_word;
    job_o.row  = cmd_i.read_row;
    job_o.col  = cmd_i.read_col;
    case (cmd_i.action)
      ACT_PUT: begin
        if (cmd_i.char_word[15:8] == 8'h00) begin
          job_o.word = {attr_q, cmd_i.char_word[7:0]};
        end
        job_o.op = (cmd_i.char_word[7:0] == NL_CODE) ? JOB_NEWLINE : JOB_PUT;
      end
      ACT_CLEAR: begin
        job_o.op   = JOB_CLEAR;
        job_o.word = {attr_q, SPACE_CODE};
      end
      ACT_READ: begin
        job_o.op = read_ok ? JOB_READ : JOB_NOP;
      end
      default: begin
        job_o.op = JOB_NOP;
      end
    endcase
  end

endmodule

// File: rtl/tcw_back.sv
// Back end of the console writer: cursor, screen store sequencing (put,
// read, scroll copy, fills) and the result register. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  job_t head_i,
  output logic pop_o,
  output logic wipe_busy_o,
  output logic result_valid_o,
  output res_t result_o
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLUMNS);
  localparam int FILL_BASE  = (ROWS - 1) * COLUMNS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [WORD_W-1:0] fill_q, fill_d;
  logic              emit_q, emit_d;
  logic              scr_q, scr_d;
  logic              pend_q, pend_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic              valid_q, valid_d;
  res_t              res_q, res_d;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;

  logic              wrap_row, at_bottom, scroll_hit;
  logic [RW-1:0]     new_row;
  logic [CW-1:0]     new_col;
  logic [AW-1:0]     cur_addr, rd_addr;

  tcw_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CELL_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Cursor step for a put or newline
  assign wrap_row   = (head_i.op == JOB_NEWLINE) || (col_q == CW'(COLUMNS - 1));
  assign at_bottom  = (row_q == RW'(ROWS - 1));
  assign scroll_hit = wrap_row && at_bottom;
  assign new_row    = (wrap_row && !at_bottom) ? row_q + 1'b1 : row_q;
  assign new_col    = wrap_row ? '0 : col_q + 1'b1;

  assign cur_addr = AW'(int'(row_q) * COLUMNS + int'(col_q));
  assign rd_addr  = AW'(int'(head_i.row) * COLUMNS + int'(head_i.col));

  assign wipe_busy_o    = (state_q == S_FILL) && !emit_q;
  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    fill_d  = fill_q;
    emit_d  = emit_q;
    scr_d   = scr_q;
    pend_d  = pend_q;
    row_d   = row_q;
    col_d   = col_q;
    valid_d = 1'b0;
    res_d   = res_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = fill_q;
    raddr   = '0;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          res_d.cursor_row = ROW_W'(row_q);
          res_d.cursor_col = COL_W'(col_q);
          res_d.read_data  = '0;
          res_d.scrolled   = 1'b0;
          case (head_i.op)
            JOB_PUT, JOB_NEWLINE: begin
              if (head_i.op == JOB_PUT) begin
                we    = 1'b1;
                waddr = cur_addr;
                wdata = head_i.word;
              end
              row_d = new_row;
              col_d = new_col;
              if (scroll_hit) begin
                state_d = S_SCROLL;
                idx_d   = '0;
                pend_d  = 1'b0;
              end else begin
                valid_d          = 1'b1;
                res_d.cursor_row = ROW_W'(new_row);
                res_d.cursor_col = COL_W'(new_col);
              end
            end
            JOB_CLEAR: begin
              state_d = S_FILL;
              idx_d   = '0;
              fill_d  = head_i.word;
              emit_d  = 1'b1;
              scr_d   = 1'b0;
            end
            JOB_READ: begin
              raddr   = rd_addr;
              state_d = S_READ;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        valid_d         = 1'b1;
        res_d.read_data = rdata;
        state_d         = S_IDLE;
      end
      // Copy each cell up one row: read ahead, write each word in the cycle after its read
      S_SCROLL: begin
        raddr  = idx_q + AW'(COLUMNS);
        pend_d = 1'b1;
        if (pend_q) begin
          we    = 1'b1;
          waddr = idx_q - 1'b1;
          wdata = rdata;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == AW'(FILL_BASE - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        we      = 1'b1;
        waddr   = idx_q - 1'b1;
        wdata   = rdata;
        fill_d  = {8'h00, SPACE_CODE};
        emit_d  = 1'b1;
        scr_d   = 1'b1;
        state_d = S_FILL;
      end
      // Fill from idx to the end of the store
      S_FILL: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = fill_q;
        idx_d = idx_q + 1'b1;
        if (idx_q == AW'(CELL_COUNT - 1)) begin
          state_d = S_IDLE;
          if (emit_q) begin
            valid_d          = 1'b1;
            res_d.cursor_row = ROW_W'(row_q);
            res_d.cursor_col = COL_W'(col_q);
            res_d.read_data  = '0;
            res_d.scrolled   = scr_q;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Reset starts a wipe of the store to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL;
      idx_q   <= '0;
      fill_q  <= '0;
      emit_q  <= 1'b0;
      scr_q   <= 1'b0;
      pend_q  <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      fill_q  <= fill_d;
      emit_q  <= emit_d;
      scr_q   <= scr_d;
      pend_q  <= pend_d;
      row_q   <= row_d;
      col_q   <= col_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Checks
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(row_q) < ROWS)
    else $error("cursor row beyond the last row");

  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (state_q == S_IDLE))
    else $error("result shown while a job is still running");

  a_drain_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (idx_q == AW'(FILL_BASE)))
    else $error("scroll copy ended at the wrong cell");

  a_scroll_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.scrolled) |-> (res_q.cursor_col == '0))
    else $error("scroll result with cursor off column zero");

endmodule

// File: rtl/text_console_writer.sv
// Top level of the text console writer: front end, job queue and back end.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back (and tcw_ram).
`timescale 1ns / 1ps

// Text console writer. A command is taken when start is high and busy low;
// its result appears on res_o for one cycle with result_valid_o, and the
// receiver cannot stall it. Commands are classified in the front end and
// queued (two deep) for the back end, which owns a ROWS x COLUMNS cell
// store in a single-write, single-read RAM. A put or a newline without
// scroll passes through the queue entry and the result register, a read
// also through the RAM read data register. Scroll, clear and the reset
// wipe are bound by the one RAM write port: a scroll copies each cell up
// one row and then fills the last row, a clear fills every cell. After
// reset the store is wiped to zero with busy high; the attribute register
// can be written throughout.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  output logic       result_valid_o,
  output res_t       res_o
);

  logic q_full, q_empty, push, pop, wipe_busy;
  job_t job_in, job_head;

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .cmd_i      (cmd_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .wipe_busy_i(wipe_busy),
    .push_o     (push),
    .job_o      (job_in)
  );

  tcw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(job_in),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .head_o (job_head)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .head_i        (job_head),
    .pop_o         (pop),
    .wipe_busy_o   (wipe_busy),
    .result_valid_o(result_valid_o),
    .result_o      (res_o)
  );

endmodule
